@@ rtl/rocsf_pkg.sv @@
// ----------------------------------------------------------------------------
// rocsf_pkg
// Shared types and constants of the rate-of-change spike filter.
// ----------------------------------------------------------------------------
package rocsf_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int TIME_BITS      = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RATE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RATE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE     = 2'd2;

  typedef enum logic [1:0] {
    MODE_LEFT  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_AND   = 2'd2,
    MODE_OR    = 2'd3
  } mode_t;

  // how the back end judges one sample
  typedef enum logic [2:0] {
    RULE_FIRST = 3'd0,
    RULE_KEEP  = 3'd1,
    RULE_LEFT  = 3'd2,
    RULE_RIGHT = 3'd3,
    RULE_AND   = 3'd4,
    RULE_OR    = 3'd5
  } rule_t;

  typedef struct packed {
    rule_t rule;
    logic  last;
  } job_ctl_t;

endpackage

@@ rtl/rocsf_front.sv @@
// ----------------------------------------------------------------------------
// rocsf_front
// Accepts samples, tracks the series and the held sample, and turns each
// request into zero, one or two judge jobs for the queue.
// ----------------------------------------------------------------------------
module rocsf_front #(
  parameter int VALUE_BITS = rocsf_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rocsf_pkg::TIME_BITS-1:0]     in_sample_time,
  input  logic signed [VALUE_BITS-1:0]        in_sample_value,
  input  logic                                in_present,
  input  logic                                in_end_of_series,
  input  rocsf_pkg::mode_t                    mode,
  input  logic                                space_ok,
  output logic [1:0]                          push_cnt,
  output rocsf_pkg::job_ctl_t                 job0_ctl,
  output logic [rocsf_pkg::TIME_BITS-1:0]     job0_time,
  output logic signed [VALUE_BITS-1:0]        job0_value,
  output rocsf_pkg::job_ctl_t                 job1_ctl
);
  import rocsf_pkg::*;

  logic                        started_r, started_nxt;
  logic                        held_valid_r, held_valid_nxt;
  logic [TIME_BITS-1:0]        held_time_r;
  logic signed [VALUE_BITS-1:0] held_value_r;
  logic                        accept;
  logic                        job_a, job_b, job_c;
  rule_t                       rule_a, rule_b, rule_c;

  assign in_stall = !space_ok;
  assign accept   = in_valid && !in_stall;

  // held sample judged with its right neighbour
  assign job_a = in_present && started_r && held_valid_r;
  // new sample judged now
  assign job_b = in_present && (!started_r || mode == MODE_LEFT || in_end_of_series);
  // held sample flushed by a missing end item
  assign job_c = !in_present && in_end_of_series && held_valid_r;

  always_comb begin
    case (mode)
      MODE_LEFT:  rule_a = RULE_LEFT;
      MODE_RIGHT: rule_a = RULE_RIGHT;
      MODE_AND:   rule_a = RULE_AND;
      MODE_OR:    rule_a = RULE_OR;
      default:    rule_a = RULE_LEFT;
    endcase
  end

  assign rule_c = (mode == MODE_RIGHT) ? RULE_KEEP : RULE_LEFT;
  assign rule_b = !started_r ? RULE_FIRST : rule_c;

  always_comb begin
    push_cnt        = 2'd0;
    job0_ctl.rule   = rule_c;
    job0_ctl.last   = in_end_of_series;
    job0_time       = held_time_r;
    job0_value      = held_value_r;
    job1_ctl.rule   = rule_b;
    job1_ctl.last   = in_end_of_series;
    if (job_a) begin
      job0_ctl.rule = rule_a;
      job0_ctl.last = in_end_of_series && !job_b;
      push_cnt      = job_b ? 2'd2 : 2'd1;
    end else if (job_b) begin
      job0_ctl.rule = rule_b;
      job0_time     = in_sample_time;
      job0_value    = in_sample_value;
      push_cnt      = 2'd1;
    end else if (job_c) begin
      push_cnt      = 2'd1;
    end
    if (!accept) begin
      push_cnt = 2'd0;
    end
  end

  always_comb begin
    started_nxt    = started_r;
    held_valid_nxt = held_valid_r;
    if (in_present) begin
      started_nxt    = 1'b1;
      held_valid_nxt = started_r && mode != MODE_LEFT;
    end
    if (in_end_of_series) begin
      started_nxt    = 1'b0;
      held_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      held_valid_r <= 1'b0;
    end else if (accept) begin
      started_r    <= started_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_present) begin
      held_time_r  <= in_sample_time;
      held_value_r <= in_sample_value;
    end
  end

endmodule

@@ rtl/rocsf_queue.sv @@
// ----------------------------------------------------------------------------
// rocsf_queue
// Short job queue between front and back, up to two writes and one read a cycle.
// ----------------------------------------------------------------------------
module rocsf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rocsf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  logic [WIDTH-1:0] push0_data,
  input  logic [WIDTH-1:0] push1_data,
  output logic             space_ok,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  import rocsf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign space_ok   = count_r <= CW'(DEPTH - 2);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem[rd_ptr_r];
  assign wr_ptr_nxt = wr_ptr_r + AW'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign count_nxt  = count_r + CW'(push_cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0_data;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + AW'(1)] <= push1_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> ({1'b0, count_r} + (CW + 1)'(push_cnt)) <= (CW + 1)'(DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue underflow");
`endif

endmodule

@@ rtl/rocsf_back.sv @@
// ----------------------------------------------------------------------------
// rocsf_back
// Judges one job a cycle unless out_stall holds it, by exact cross-multiplied
// rate tests against the last kept sample and the right neighbour; registers it.
// ----------------------------------------------------------------------------
module rocsf_back #(
  parameter int VALUE_BITS = rocsf_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [VALUE_BITS-1:0]        max_rate,
  input  logic signed [VALUE_BITS-1:0]        min_rate,
  input  logic                                pop_valid,
  output logic                                pop,
  input  rocsf_pkg::job_ctl_t                 job_ctl,
  input  logic [rocsf_pkg::TIME_BITS-1:0]     job_time,
  input  logic signed [VALUE_BITS-1:0]        job_value,
  input  logic [rocsf_pkg::TIME_BITS-1:0]     job_rtime,
  input  logic signed [VALUE_BITS-1:0]        job_rvalue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rocsf_pkg::TIME_BITS-1:0]     out_time,
  output logic signed [VALUE_BITS-1:0]        out_value,
  output logic                                out_keep,
  output logic                                out_last_of_run
);
  import rocsf_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int TW = TIME_BITS;
  localparam int DW = VB + TW + 2;

  logic [TW-1:0]        ref_time_r;
  logic signed [VB-1:0] ref_value_r;
  logic                 out_valid_r;
  logic [TW-1:0]        out_time_r;
  logic signed [VB-1:0] out_value_r;
  logic                 out_keep_r;
  logic                 out_last_r;

  logic signed [VB:0]   ldv, rdv;
  logic signed [TW:0]   ldt, rdt;
  logic signed [DW-1:0] d_lmax, d_lmin, d_rmax, d_rmin;
  logic                 lg, ll, rg, rl;
  logic                 keep_c;

  // dv - lim * dt, exact
  function automatic logic signed [DW-1:0] diff_f(input logic signed [VB:0] dv,
                                                  input logic signed [TW:0] dt,
                                                  input logic signed [VB-1:0] lim);
    logic signed [VB+TW:0] prod;
    prod = lim * dt;
    return DW'(dv) - DW'(prod);
  endfunction

  function automatic logic above_f(input logic signed [DW-1:0] d,
                                   input logic dt_neg,
                                   input logic signed [VB-1:0] lim);
    logic pos, neg, zero;
    neg  = d[DW-1];
    zero = d == '0;
    pos  = !neg && !zero;
    return dt_neg ? (neg || (zero && !lim[VB-1] && lim != '0))
                  : (pos || (zero && lim[VB-1]));
  endfunction

  function automatic logic below_f(input logic signed [DW-1:0] d,
                                   input logic dt_neg,
                                   input logic signed [VB-1:0] lim);
    logic pos, neg, zero;
    neg  = d[DW-1];
    zero = d == '0;
    pos  = !neg && !zero;
    return dt_neg ? (pos || (zero && lim[VB-1]))
                  : (neg || (zero && !lim[VB-1] && lim != '0));
  endfunction

  assign ldv = (VB + 1)'(job_value) - (VB + 1)'(ref_value_r);
  assign rdv = (VB + 1)'(job_rvalue) - (VB + 1)'(job_value);
  assign ldt = $signed({1'b0, job_time}) - $signed({1'b0, ref_time_r});
  assign rdt = $signed({1'b0, job_rtime}) - $signed({1'b0, job_time});

  assign d_lmax = diff_f(ldv, ldt, max_rate);
  assign d_lmin = diff_f(ldv, ldt, min_rate);
  assign d_rmax = diff_f(rdv, rdt, max_rate);
  assign d_rmin = diff_f(rdv, rdt, min_rate);

  assign lg = above_f(d_lmax, ldt[TW], max_rate);
  assign ll = below_f(d_lmin, ldt[TW], min_rate);
  assign rg = above_f(d_rmax, rdt[TW], max_rate);
  assign rl = below_f(d_rmin, rdt[TW], min_rate);

  always_comb begin
    case (job_ctl.rule)
      RULE_FIRST: keep_c = 1'b1;
      RULE_KEEP:  keep_c = 1'b1;
      RULE_LEFT:  keep_c = !(lg || ll);
      RULE_RIGHT: keep_c = !(rg || rl);
      RULE_AND:   keep_c = !((lg && rg) || ll || rl);
      RULE_OR:    keep_c = !(lg || rg || (ll && rl));
      default:    keep_c = 1'b1;
    endcase
  end

  assign pop = pop_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ref_time_r  <= '0;
      ref_value_r <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop && keep_c) begin
        ref_time_r  <= job_time;
        ref_value_r <= job_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_time_r  <= job_time;
      out_value_r <= job_value;
      out_keep_r  <= keep_c;
      out_last_r  <= job_ctl.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_time        = out_time_r;
  assign out_value       = out_value_r;
  assign out_keep        = out_keep_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTH
  a_first_kept: assert property (@(posedge clk) disable iff (!rst_n)
    pop && job_ctl.rule == RULE_FIRST |=> out_keep_r)
    else $error("first sample of series rejected");

  a_flush_kept: assert property (@(posedge clk) disable iff (!rst_n)
    pop && job_ctl.rule == RULE_KEEP |=> out_keep_r)
    else $error("held sample in right mode rejected at series end");

  a_ref_follows: assert property (@(posedge clk) disable iff (!rst_n)
    pop && keep_c |=> ref_time_r == $past(job_time) && ref_value_r == $past(job_value))
    else $error("reference not updated by kept sample");
`endif

endmodule

@@ rtl/rate_of_change_spike_filter.sv @@
// ----------------------------------------------------------------------------
// rate_of_change_spike_filter
// Rate-of-change spike filter top level: configuration registers, front end,
// job queue and judging back end.
// Throughput: one request a cycle unless in_stall holds it; the back end
// judges one job a cycle unless out_stall holds it, one job per result.
// Path: a request's jobs go into the job queue, then are judged into the back
// end's output register; outside left mode a sample that is neither first nor
// last in its series waits for the next present sample or the series end.
// Reset: synchronous active-low rst_n clears limits, mode, series state and
// the queue; no clearing pass, requests are taken right after reset.
// ----------------------------------------------------------------------------
module rate_of_change_spike_filter #(
  parameter int VALUE_BITS = rocsf_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rocsf_pkg::TIME_BITS-1:0]     in_sample_time,
  input  logic signed [VALUE_BITS-1:0]        in_sample_value,
  input  logic                                in_present,
  input  logic                                in_end_of_series,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rocsf_pkg::TIME_BITS-1:0]     out_time,
  output logic signed [VALUE_BITS-1:0]        out_value,
  output logic                                out_keep,
  output logic                                out_last_of_run,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rocsf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [VALUE_BITS-1:0]               cfg_data
);
  import rocsf_pkg::*;

  localparam int CTL_W = $bits(job_ctl_t);
  localparam int QW    = CTL_W + 2 * (TIME_BITS + VALUE_BITS);

  logic signed [VALUE_BITS-1:0] max_rate_r;
  logic signed [VALUE_BITS-1:0] min_rate_r;
  mode_t                        mode_r;

  logic                         space_ok;
  logic [1:0]                   push_cnt;
  job_ctl_t                     job0_ctl, job1_ctl;
  logic [TIME_BITS-1:0]         job0_time;
  logic signed [VALUE_BITS-1:0] job0_value;
  logic [QW-1:0]                push0_data, push1_data, pop_data;
  logic                         pop, pop_valid;
  job_ctl_t                     q_ctl;
  logic [TIME_BITS-1:0]         q_time, q_rtime;
  logic signed [VALUE_BITS-1:0] q_value, q_rvalue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rate_r <= '0;
      min_rate_r <= '0;
      mode_r     <= MODE_LEFT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_RATE: max_rate_r <= cfg_data;
        CFG_MIN_RATE: min_rate_r <= cfg_data;
        CFG_MODE:     mode_r     <= mode_t'(cfg_data[1:0]);
        default:      ;
      endcase
    end
  end

  rocsf_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_time   (in_sample_time),
    .in_sample_value  (in_sample_value),
    .in_present       (in_present),
    .in_end_of_series (in_end_of_series),
    .mode             (mode_r),
    .space_ok         (space_ok),
    .push_cnt         (push_cnt),
    .job0_ctl         (job0_ctl),
    .job0_time        (job0_time),
    .job0_value       (job0_value),
    .job1_ctl         (job1_ctl)
  );

  // right neighbour of a job is always the incoming sample
  assign push0_data = {job0_ctl, job0_time, job0_value, in_sample_time, in_sample_value};
  assign push1_data = {job1_ctl, in_sample_time, in_sample_value,
                       in_sample_time, in_sample_value};

  rocsf_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0_data (push0_data),
    .push1_data (push1_data),
    .space_ok   (space_ok),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  assign {q_ctl, q_time, q_value, q_rtime, q_rvalue} = pop_data;

  rocsf_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .max_rate        (max_rate_r),
    .min_rate        (min_rate_r),
    .pop_valid       (pop_valid),
    .pop             (pop),
    .job_ctl         (q_ctl),
    .job_time        (q_time),
    .job_value       (q_value),
    .job_rtime       (q_rtime),
    .job_rvalue      (q_rvalue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_time        (out_time),
    .out_value       (out_value),
    .out_keep        (out_keep),
    .out_last_of_run (out_last_of_run)
  );

endmodule

@@ bench/tb_rate_of_change_spike_filter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rate_of_change_spike_filter
// Self-checking bench for the rate-of-change spike filter. A driver feeds
// sample requests from a queue and a monitor checks every verdict against a
// local predictor of the filter. Both sides idle at random. The register
// settings cover all four modes, limit extremes and min above max, and two
// long output holds fill the block. The random series are mostly well formed
// and are mixed with noise and with series left open.
// ----------------------------------------------------------------------------
module tb_rate_of_change_spike_filter;
  import rocsf_pkg::*;

  localparam int VB          = VALUE_BITS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int RAND_ITEMS  = 1350;

  typedef struct {
    logic [TIME_BITS-1:0] t;
    logic signed [VB-1:0] v;
    logic                 present;
    logic                 eos;
  } sample_req_t;

  typedef struct {
    logic [TIME_BITS-1:0] t;
    logic signed [VB-1:0] v;
    logic                 keep;
    logic                 last;
  } verdict_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [TIME_BITS-1:0]    in_sample_time = '0;
  logic signed [VB-1:0]    in_sample_value = '0;
  logic                    in_present = 1'b0;
  logic                    in_end_of_series = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [TIME_BITS-1:0]    out_time;
  logic signed [VB-1:0]    out_value;
  logic                    out_keep;
  logic                    out_last_of_run;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [VB-1:0]           cfg_data = '0;

  // predictor state and register copies
  logic signed [VB-1:0]    lim_max = '0;
  logic signed [VB-1:0]    lim_min = '0;
  mode_t                   cur_mode = MODE_LEFT;
  bit                      in_series = 1'b0;
  logic [TIME_BITS-1:0]    anchor_time = '0;
  logic signed [VB-1:0]    anchor_value = '0;
  bit                      pend_valid = 1'b0;
  logic [TIME_BITS-1:0]    pend_time = '0;
  logic signed [VB-1:0]    pend_value = '0;

  sample_req_t req_pending[$];
  verdict_t    verdict_q[$];
  sample_req_t cur_req;
  verdict_t    head;

  int reqs_queued = 0;
  int reqs_taken = 0;
  int verdicts_seen = 0;
  int mismatches = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  bit in_rush = 1'b0;
  int out_gap = 0;
  bit out_rush = 1'b0;
  int long_hold = 0;

  rate_of_change_spike_filter #(
    .VALUE_BITS(VB)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_time  (in_sample_time),
    .in_sample_value (in_sample_value),
    .in_present      (in_present),
    .in_end_of_series(in_end_of_series),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_time        (out_time),
    .out_value       (out_value),
    .out_keep        (out_keep),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sign of dv - lim * dt, exact
  function automatic int excess_sign(longint dv, longint dt, longint lim);
    logic signed [79:0] wv, wt, wl, d;
    wv = dv;
    wt = dt;
    wl = lim;
    d = wv - wl * wt;
    if (d < 0) return -1;
    return (d == 0) ? 0 : 1;
  endfunction

  function automatic bit rate_over(longint dv, longint dt, longint lim);
    int s;
    s = excess_sign(dv, dt, lim);
    if (dt >= 0) return s > 0 || (s == 0 && lim < 0);
    return s < 0 || (s == 0 && lim > 0);
  endfunction

  function automatic bit rate_under(longint dv, longint dt, longint lim);
    int s;
    s = excess_sign(dv, dt, lim);
    if (dt >= 0) return s < 0 || (s == 0 && lim > 0);
    return s > 0 || (s == 0 && lim < 0);
  endfunction

  function automatic bit judge_keep(logic [TIME_BITS-1:0] t, logic signed [VB-1:0] v,
                                    bit has_right, logic [TIME_BITS-1:0] rt,
                                    logic signed [VB-1:0] rv);
    longint ldv, ldt, rdv, rdt;
    bit lg, ll, rg, rl;
    ldv = longint'(v) - longint'(anchor_value);
    ldt = longint'(t) - longint'(anchor_time);
    lg = rate_over(ldv, ldt, longint'(lim_max));
    ll = rate_under(ldv, ldt, longint'(lim_min));
    rg = 1'b0;
    rl = 1'b0;
    if (has_right) begin
      rdv = longint'(rv) - longint'(v);
      rdt = longint'(rt) - longint'(t);
      rg = rate_over(rdv, rdt, longint'(lim_max));
      rl = rate_under(rdv, rdt, longint'(lim_min));
    end
    if (cur_mode == MODE_LEFT) return !(lg || ll);
    if (!has_right) return (cur_mode == MODE_RIGHT) ? 1'b1 : !(lg || ll);
    case (cur_mode)
      MODE_RIGHT: return !(rg || rl);
      MODE_AND:   return !((lg && rg) || ll || rl);
      default:    return !(lg || rg || (ll && rl));
    endcase
  endfunction

  function automatic void predict_sample(sample_req_t s);
    verdict_t found[2];
    int n;
    bit k;
    n = 0;
    if (s.present) begin
      if (!in_series) begin
        in_series = 1'b1;
        anchor_time = s.t;
        anchor_value = s.v;
        found[n] = '{s.t, s.v, 1'b1, 1'b0};
        n++;
      end else begin
        if (pend_valid) begin
          k = judge_keep(pend_time, pend_value, 1'b1, s.t, s.v);
          found[n] = '{pend_time, pend_value, k, 1'b0};
          n++;
          if (k) begin
            anchor_time = pend_time;
            anchor_value = pend_value;
          end
          pend_valid = 1'b0;
        end
        if (cur_mode == MODE_LEFT) begin
          k = judge_keep(s.t, s.v, 1'b0, '0, '0);
          found[n] = '{s.t, s.v, k, 1'b0};
          n++;
          if (k) begin
            anchor_time = s.t;
            anchor_value = s.v;
          end
        end else begin
          pend_valid = 1'b1;
          pend_time = s.t;
          pend_value = s.v;
        end
      end
    end
    if (s.eos) begin
      if (pend_valid) begin
        k = judge_keep(pend_time, pend_value, 1'b0, '0, '0);
        found[n] = '{pend_time, pend_value, k, 1'b0};
        n++;
      end
      if (n > 0) found[n-1].last = 1'b1;
      in_series = 1'b0;
      pend_valid = 1'b0;
      pend_time = '0;
      pend_value = '0;
      anchor_time = '0;
      anchor_value = '0;
    end
    for (int i = 0; i < n; i++) verdict_q.push_back(found[i]);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("ERROR %0t: %s", $time, what);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_sample(cur_req);
        reqs_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (req_pending.size() > 0) begin
          cur_req = req_pending.pop_front();
          in_sample_time <= cur_req.t;
          in_sample_value <= cur_req.v;
          in_present <= cur_req.present;
          in_end_of_series <= cur_req.eos;
          in_valid <= 1'b1;
          if ($urandom_range(0, 23) == 0) in_rush = !in_rush;
          in_gap = in_rush ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result time %0d value %0d",
                                  out_time, out_value));
        end else begin
          head = verdict_q.pop_front();
          if (out_time !== head.t)
            flag_mismatch($sformatf("out_time %0d, want %0d", out_time, head.t));
          if (out_value !== head.v)
            flag_mismatch($sformatf("out_value %0d, want %0d (time %0d)",
                                    out_value, head.v, head.t));
          if (out_keep !== head.keep)
            flag_mismatch($sformatf("out_keep %0b, want %0b (time %0d)",
                                    out_keep, head.keep, head.t));
          if (out_last_of_run !== head.last)
            flag_mismatch($sformatf("out_last_of_run %0b, want %0b (time %0d)",
                                    out_last_of_run, head.last, head.t));
        end
        verdicts_seen++;
        // long hold so the block backs up into its input
        if (verdicts_seen == 250 || verdicts_seen == 800) long_hold = 400;
        if ($urandom_range(0, 23) == 0) out_rush = !out_rush;
        out_gap = out_rush ? 0 : $urandom_range(0, 14);
      end
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles with no request moving", idle_cycles);
      $display("rate_of_change_spike_filter test failed");
      $finish;
    end
  end

  function automatic void queue_req(logic [TIME_BITS-1:0] t, logic signed [VB-1:0] v,
                                    bit present, bit eos);
    sample_req_t r;
    r = '{t, v, present, eos};
    req_pending.push_back(r);
    reqs_queued++;
  endfunction

  task automatic drain();
    while (!(reqs_taken == reqs_queued && verdict_q.size() == 0)) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [VB-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_RATE: lim_max = data;
      CFG_MIN_RATE: lim_min = data;
      CFG_MODE:     cur_mode = mode_t'(data[1:0]);
      default: ;
    endcase
  endtask

  task automatic configure(input logic [VB-1:0] hi, input logic [VB-1:0] lo, input mode_t m);
    drain();
    write_reg(CFG_MAX_RATE, hi);
    write_reg(CFG_MIN_RATE, lo);
    write_reg(CFG_MODE, VB'(m));
    settings_used++;
  endtask

  // one series with rates around the limits; some are left open
  task automatic gen_series(input logic signed [VB-1:0] hi, input logic signed [VB-1:0] lo);
    int len, dt_kind, pick, jit, dt;
    bit broken, present, eos;
    logic [TIME_BITS-1:0] gt;
    logic signed [VB-1:0] gv;
    longint rate;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
    broken = ($urandom_range(0, 9) == 0);
    gt = $urandom;
    gv = $urandom;
    for (int i = 0; i < len; i++) begin
      dt_kind = $urandom_range(0, 9);
      if (dt_kind < 7) dt = $urandom_range(1, 60);
      else if (dt_kind == 7) dt = 0;
      else if (dt_kind == 8) dt = -int'($urandom_range(1, 5));
      else dt = $urandom;
      pick = $urandom_range(0, 5);
      jit = $urandom_range(0, 4);
      jit = jit - 2;
      case (pick)
        0, 1:    rate = longint'(hi) + jit;
        2, 3:    rate = longint'(lo) + jit;
        4:       rate = (longint'(hi) + longint'(lo)) / 2;
        default: rate = longint'($signed($urandom));
      endcase
      gt = gt + dt;
      gv = VB'(longint'(gv) + rate * dt);
      present = ($urandom_range(0, 6) != 0);
      eos = !broken && (i == len - 1);
      queue_req(gt, gv, present, eos);
    end
  endtask

  task automatic pick_config(input int phase);
    logic signed [VB-1:0] hi, lo;
    case (phase % 6)
      0: begin
        hi = 32'sh7FFFFFFF;
        lo = 32'sh80000000;
      end
      1: begin
        hi = 32'sh80000000;
        lo = 32'sh7FFFFFFF;
      end
      2: begin
        hi = '0;
        lo = '0;
      end
      default: begin
        hi = $urandom_range(1, 32'h60000);
        case ($urandom_range(0, 3))
          0:       lo = -$signed(VB'($urandom_range(0, 32'h60000)));
          1:       lo = hi + $urandom_range(0, 32'h10000);
          default: lo = -hi;
        endcase
      end
    endcase
    configure(hi, lo, mode_t'(phase % 4));
  endtask

  initial begin
    int rand_goal, phase_goal, phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // left mode, limits of plus and minus one per second
    configure(32'sh10000, -32'sh10000, MODE_LEFT);
    queue_req(32'd100, 32'sh0, 1'b1, 1'b0);
    queue_req(32'd101, 32'sh8000, 1'b1, 1'b0);
    queue_req(32'd102, 32'sh38000, 1'b1, 1'b0);
    queue_req(32'd103, 32'sh18000, 1'b1, 1'b0);
    queue_req(32'd104, 32'sh28000, 1'b1, 1'b0);
    queue_req(32'd105, $urandom, 1'b0, 1'b0);
    queue_req(32'd104, 32'sh28000, 1'b1, 1'b0);
    queue_req(32'd90, 32'sh7FFFFFFF, 1'b1, 1'b0);
    queue_req(32'hFFFFFFFF, 32'sh80000000, 1'b1, 1'b1);

    // right mode: held sample judged by its neighbor, flushed at series end
    configure(32'sh10000, -32'sh10000, MODE_RIGHT);
    queue_req(32'd10, 32'sh0, 1'b1, 1'b0);
    queue_req(32'd11, 32'sh40000, 1'b1, 1'b0);
    queue_req(32'd12, 32'sh8000, 1'b1, 1'b0);
    queue_req(32'd13, 32'sh0, 1'b0, 1'b1);
    queue_req(32'd20, 32'sh0, 1'b0, 1'b1);
    queue_req(32'd0, 32'sh80000000, 1'b1, 1'b1);

    // and mode with min above max
    configure(32'sh80000000, 32'sh7FFFFFFF, MODE_AND);
    queue_req(32'd5, 32'sh0, 1'b1, 1'b0);
    queue_req(32'd6, 32'sh10000, 1'b1, 1'b0);
    queue_req(32'd7, 32'shFFFF0000, 1'b1, 1'b0);
    queue_req(32'd8, 32'sh0, 1'b1, 1'b1);

    // or mode at the widest limits, then a switch to left mode mid-series
    configure(32'sh7FFFFFFF, 32'sh80000000, MODE_OR);
    queue_req(32'd1, 32'sh10000, 1'b1, 1'b0);
    queue_req(32'd3, -32'sh50000, 1'b1, 1'b0);
    queue_req(32'd2, 32'sh70000, 1'b1, 1'b0);
    configure(32'sh10000, -32'sh10000, MODE_LEFT);
    queue_req(32'd4, 32'sh10000, 1'b1, 1'b1);

    rand_goal = reqs_queued + RAND_ITEMS;
    phase = 0;
    while (reqs_queued < rand_goal) begin
      pick_config(phase);
      phase_goal = reqs_queued + 105;
      while (reqs_queued < phase_goal && reqs_queued < rand_goal) begin
        if ($urandom_range(0, 11) == 0)
          queue_req($urandom, $urandom, 1'($urandom_range(0, 1)),
                    $urandom_range(0, 7) == 0);
        else
          gen_series(lim_max, lim_min);
      end
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d sample requests under %0d register settings, all four modes",
             reqs_taken, settings_used);
    $display("checked %0d results, %0d mismatches", verdicts_seen, mismatches);
    if (mismatches == 0)
      $display("rate_of_change_spike_filter test passed");
    else
      $display("rate_of_change_spike_filter test failed");
    $finish;
  end

endmodule

@@ rate_of_change_spike_filter.f @@
rtl/rocsf_pkg.sv
rtl/rocsf_front.sv
rtl/rocsf_queue.sv
rtl/rocsf_back.sv
rtl/rate_of_change_spike_filter.sv
bench/tb_rate_of_change_spike_filter.sv
